// ----- hw/rtl/box_blur_band_threshold_defines.svh -----
// Assertion macros for the box blur band threshold block.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef BOX_BLUR_BAND_THRESHOLD_DEFINES_SVH
`define BOX_BLUR_BAND_THRESHOLD_DEFINES_SVH

// implication checked outside reset
`define BBT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that also runs during reset
`define BBT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/bbt_pkg.sv -----
// Shared types, constants and helpers for the box blur band threshold block.
// No dependencies.
package bbt_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int SUM_W     = 10;              // R+G+B, 0..765
	localparam int TOTAL_W   = 13;              // nine sums, up to 6885
	localparam int DIV_W     = 5;               // 3 * count, up to 27
	localparam int MEM_W     = 2 * SUM_W + 8;   // {above sum, centre sum, centre alpha}

	localparam logic [11:0] RST_WIDTH  = 12'd640;
	localparam logic [15:0] RST_HEIGHT = 16'd480;
	localparam logic [7:0]  RST_LOW    = 8'd127;
	localparam logic [7:0]  RST_HIGH   = 8'd178;
	localparam logic [7:0]  MASK_ON    = 8'hFF;
	localparam logic [7:0]  MASK_OFF   = 8'h00;

	typedef enum logic [2:0] {
		CFG_WIDTH  = 3'd0,
		CFG_HEIGHT = 3'd1,
		CFG_LOW    = 3'd2,
		CFG_HIGH   = 3'd3
	} cfg_idx_t;

	typedef enum logic [0:0] {
		REQ_PIXEL = 1'b0,
		REQ_FLUSH = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RMW,
		ST_SUM,
		ST_CMP
	} st_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pix_t;

	typedef struct packed {
		logic [7:0] mask_value;
		logic [7:0] out_alpha;
		logic       frame_last;
	} res_t;

	typedef struct packed {
		logic             shift;
		logic             calc;
		logic [SUM_W-1:0] above;
		logic [SUM_W-1:0] centre;
		logic [SUM_W-1:0] sum;
		logic             top_ok;
		logic             bot_ok;
		logic             left_ok;
		logic             right_ok;
	} win_ctl_t;

	// divisor 3 * rows * columns of the in-frame part of the window
	function automatic logic [DIV_W-1:0] band_div(input logic [1:0] nrows,
		input logic [1:0] ncols);
		return DIV_W'(nrows * ncols * 3);
	endfunction

endpackage

// ----- hw/rtl/bbt_line_mem.sv -----
// Line buffer memory: per column the sum two rows back, plus sum and alpha
// one row back. One read and one write port, registered read. Uses bbt_pkg.
module bbt_line_mem (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [bbt_pkg::COL_W-1:0] rd_addr,
	output logic [bbt_pkg::MEM_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [bbt_pkg::COL_W-1:0] wr_addr,
	input  logic [bbt_pkg::MEM_W-1:0] wr_data
);
	import bbt_pkg::*;

	logic [MEM_W-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/bbt_window.sv -----
// 3x3 window of brightness sums with the border-masked total and divisor.
// Uses bbt_pkg (win_ctl_t, band_div).
module bbt_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bbt_pkg::win_ctl_t           ctl,
	output logic [bbt_pkg::TOTAL_W-1:0] total,
	output logic [bbt_pkg::DIV_W-1:0]   divisor
);
	import bbt_pkg::*;

	// [row * 3 + slot], row 0 top, slot 2 newest
	logic [SUM_W-1:0]   win_q [9];
	logic [TOTAL_W-1:0] total_n;
	logic [TOTAL_W-1:0] total_q;
	logic [DIV_W-1:0]   div_q;
	logic [2:0]         row_ok;
	logic [2:0]         col_ok;
	logic [1:0]         nrows;
	logic [1:0]         ncols;

	assign row_ok = {ctl.bot_ok, 1'b1, ctl.top_ok};
	assign col_ok = {ctl.right_ok, 1'b1, ctl.left_ok};
	assign nrows  = 2'd1 + 2'(ctl.top_ok) + 2'(ctl.bot_ok);
	assign ncols  = 2'd1 + 2'(ctl.left_ok) + 2'(ctl.right_ok);

	always_comb begin
		total_n = '0;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				if (row_ok[r] && col_ok[k]) begin
					total_n = total_n + TOTAL_W'(win_q[r*3+k]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (ctl.shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= ctl.above;
			win_q[5] <= ctl.centre;
			win_q[8] <= ctl.sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.calc) begin
			total_q <= total_n;
			div_q   <= band_div(nrows, ncols);
		end
	end

	assign total   = total_q;
	assign divisor = div_q;

endmodule

// ----- hw/rtl/box_blur_band_threshold.sv -----
// Result: a result is offered after the item that emits it passes the RMW, SUM and CMP states; results lag
// the input stream by frame_width+1 items (host appends flush items per frame).
// Flow: an item is taken only while idle, so each finishes before the next is taken; an ignored flush ends at once.
// Steps: line memory read-modify-write, then for emitting items window sum and band compare (waits for res_ready).
// Reset: arst_n clears sequencer, counters, window and registers to defaults; line
// memory contents are not cleared and need no clearing pass.
`include "box_blur_band_threshold_defines.svh"

module box_blur_band_threshold (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pix_valid,
	output logic          pix_ready,
	input  bbt_pkg::pix_t pix,
	output logic          res_valid,
	input  logic          res_ready,
	output bbt_pkg::res_t res,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [15:0]   cfg_wdata
);
	import bbt_pkg::*;

	st_t st_q, st_n;

	logic [11:0] fw_q;
	logic [15:0] fh_q;
	logic [7:0]  blo_q;
	logic [7:0]  bhi_q;
	logic [11:0] w_eff;
	logic [15:0] h_eff;

	logic [COL_W-1:0] in_col_q;
	logic [1:0]       in_row_q;   // saturates at 2
	logic [COL_W-1:0] out_col_q;
	logic [15:0]      out_row_q;

	logic             accept, stray, take;
	logic             emit_n, emit_q;
	logic             in_wrap;
	logic             out_wrap;
	logic             last_n;
	logic             load_out;
	logic             cnt_zero;

	logic [SUM_W-1:0] s_q;
	logic [7:0]       al_q;
	logic [COL_W-1:0] col_q;
	logic [7:0]       calpha_q;
	logic [7:0]       aout_q;
	logic             last_q;
	logic             res_valid_q;
	res_t             res_q;

	logic [MEM_W-1:0] rd_data;
	logic             mem_wr;
	win_ctl_t         wctl;
	logic [TOTAL_W-1:0] total;
	logic [DIV_W-1:0]   divisor;
	logic [12:0]      lo_prod;
	logic [13:0]      hi_prod;
	logic             in_band;

	assign w_eff = (fw_q == 12'd0) ? 12'd1 :
		((32'(fw_q) > MAX_WIDTH) ? 12'(MAX_WIDTH) : fw_q);
	assign h_eff = (fh_q == 16'd0) ? 16'd1 : fh_q;

	// a flush at the very start of a frame carries nothing
	assign accept = pix_valid && pix_ready;
	assign stray  = accept && (pix.req_type == REQ_FLUSH) && (in_row_q == 2'd0)
		&& (in_col_q == '0);
	assign take   = accept && !stray;

	assign emit_n   = (in_row_q == 2'd2) || ((in_row_q == 2'd1) && (in_col_q != '0));
	assign in_wrap  = (32'(in_col_q) + 1) >= 32'(w_eff);
	assign out_wrap = (32'(out_col_q) + 1) >= 32'(w_eff);
	assign last_n   = ((32'(out_row_q) + 1) >= 32'(h_eff)) && out_wrap;

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE: if (take) st_n = ST_RMW;
			ST_RMW:  st_n = emit_q ? ST_SUM : ST_IDLE;
			ST_SUM:  st_n = ST_CMP;
			ST_CMP:  if (load_out) st_n = ST_IDLE;
			default: st_n = ST_IDLE;
		endcase
	end

	always_comb begin
		pix_ready = (st_q == ST_IDLE);
		mem_wr    = (st_q == ST_RMW);
		load_out  = (st_q == ST_CMP) && (!res_valid_q || res_ready);
	end

	assign wctl.shift    = (st_q == ST_RMW);
	assign wctl.calc     = (st_q == ST_SUM);
	assign wctl.above    = rd_data[MEM_W-1 -: SUM_W];
	assign wctl.centre   = rd_data[SUM_W+7:8];
	assign wctl.sum      = s_q;
	assign wctl.top_ok   = (out_row_q != 16'd0);
	assign wctl.bot_ok   = !((32'(out_row_q) + 1) >= 32'(h_eff));
	assign wctl.left_ok  = (out_col_q != '0);
	assign wctl.right_ok = !out_wrap;

	bbt_line_mem u_mem (
		.clk     (clk),
		.rd_en   (take),
		.rd_addr (in_col_q),
		.rd_data (rd_data),
		.wr_en   (mem_wr),
		.wr_addr (col_q),
		.wr_data ({rd_data[SUM_W+7:8], s_q, al_q})
	);

	bbt_window u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (wctl),
		.total   (total),
		.divisor (divisor)
	);

	// mean in band  <=>  low*d <= total < (high+1)*d
	assign lo_prod = 13'(blo_q * divisor);
	assign hi_prod = 14'((9'(bhi_q) + 9'd1) * divisor);
	assign in_band = (total >= lo_prod) && ({1'b0, total} < hi_prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			fw_q        <= RST_WIDTH;
			fh_q        <= RST_HEIGHT;
			blo_q       <= RST_LOW;
			bhi_q       <= RST_HIGH;
			in_col_q    <= '0;
			in_row_q    <= 2'd0;
			out_col_q   <= '0;
			out_row_q   <= 16'd0;
			emit_q      <= 1'b0;
			calpha_q    <= 8'd0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_WIDTH:  fw_q  <= cfg_wdata[11:0];
					CFG_HEIGHT: fh_q  <= cfg_wdata;
					CFG_LOW:    blo_q <= cfg_wdata[7:0];
					CFG_HIGH:   bhi_q <= cfg_wdata[7:0];
					default:    ;
				endcase
			end
			if (take) begin
				emit_q <= emit_n;
				if (in_wrap) begin
					in_col_q <= '0;
					if (in_row_q != 2'd2) in_row_q <= in_row_q + 2'd1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (st_q == ST_RMW) begin
				calpha_q <= rd_data[7:0];
			end
			if (st_q == ST_SUM) begin
				if (last_n) begin
					out_col_q <= '0;
					out_row_q <= 16'd0;
					in_col_q  <= '0;
					in_row_q  <= 2'd0;
				end else if (out_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 16'd1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_q <= in_col_q;
			if (pix.req_type == REQ_FLUSH) begin
				s_q  <= '0;
				al_q <= 8'd0;
			end else begin
				s_q  <= SUM_W'(pix.red) + SUM_W'(pix.green) + SUM_W'(pix.blue);
				al_q <= pix.alpha;
			end
		end
		if (st_q == ST_RMW) begin
			aout_q <= calpha_q;
		end
		if (st_q == ST_SUM) begin
			last_q <= last_n;
		end
		if (load_out) begin
			res_q.mask_value <= in_band ? MASK_ON : MASK_OFF;
			res_q.out_alpha  <= aout_q;
			res_q.frame_last <= last_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign cnt_zero = (out_row_q == 16'd0) && (out_col_q == '0) && (in_row_q == 2'd0)
		&& (in_col_q == '0);

	`BBT_ASSERT(a_stray_ignored, (stray |=> (st_q == ST_IDLE)), "flush at frame start was not ignored")
	`BBT_ASSERT(a_last_clears, ((st_q == ST_SUM) && last_n |=> cnt_zero), "frame end did not clear counters")
	`BBT_ASSERT(a_div_valid, ((st_q == ST_CMP) |-> (divisor != '0)), "zero divisor at band compare")
	`BBT_ASSERT_ALWAYS(a_ready_idle, (pix_ready |-> !mem_wr), "item taken during line memory write")

endmodule

// ----- dv/box_blur_band_threshold_checker.sv -----
`timescale 1ns / 1ps
// Checker for box_blur_band_threshold: follows register writes, predicts mask, alpha and frame end
// for each accepted item that emits a result and compares result items in order.
// Depends on bbt_pkg.
module box_blur_band_threshold_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pix_valid,
	input  logic           pix_ready,
	input  bbt_pkg::pix_t  pix,
	input  logic           res_valid,
	input  logic           res_ready,
	input  bbt_pkg::res_t  res,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_idx,
	input  logic [15:0]    cfg_wdata,
	output int             mismatches,
	output int             pending
);
	import bbt_pkg::*;

	logic [11:0] cfg_width;
	logic [15:0] cfg_height;
	logic [7:0]  band_low;
	logic [7:0]  band_high;

	logic [9:0]  row_above [MAX_WIDTH];
	logic [17:0] row_centre [MAX_WIDTH];
	logic [9:0]  win [9];
	logic [7:0]  held_alpha;
	int unsigned in_col, in_row, out_col, out_row;

	res_t mask_expect[$];
	res_t want;

	task automatic blur_reset();
		cfg_width  = RST_WIDTH;
		cfg_height = RST_HEIGHT;
		band_low   = RST_LOW;
		band_high  = RST_HIGH;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			row_above[i]  = '0;
			row_centre[i] = '0;
		end
		for (int i = 0; i < 9; i++)
			win[i] = '0;
		held_alpha = '0;
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		mask_expect.delete();
	endtask

	task automatic blur_predict(input pix_t p);
		int unsigned w, h, s, al, col, total, cnt, mean;
		logic [9:0]  above, centre;
		logic [17:0] cstore;
		logic [7:0]  a_out;
		logic        emit, last;
		res_t        r;
		w = (cfg_width == 12'd0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
		h = (cfg_height == 16'd0) ? 1 : cfg_height;
		// flush at the very start of a frame is dropped
		if (p.req_type == REQ_FLUSH && in_row == 0 && in_col == 0)
			return;
		s = 0;
		al = 0;
		if (p.req_type == REQ_PIXEL) begin
			s = 32'(p.red) + 32'(p.green) + 32'(p.blue);
			al = 32'(p.alpha);
		end
		col = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
		above = row_above[col];
		cstore = row_centre[col];
		centre = cstore[17:8];
		row_above[col] = centre;
		row_centre[col] = {s[9:0], al[7:0]};
		for (int rr = 0; rr < 3; rr++) begin
			win[rr * 3] = win[rr * 3 + 1];
			win[rr * 3 + 1] = win[rr * 3 + 2];
		end
		win[2] = above;
		win[5] = centre;
		win[8] = s[9:0];
		a_out = held_alpha;
		held_alpha = cstore[7:0];

		emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			if (in_row < 32'h1FFFF)
				in_row++;
		end
		if (!emit)
			return;

		total = 0;
		cnt = 0;
		for (int rr = 0; rr < 3; rr++) begin
			if (rr == 0 && out_row == 0)
				continue;
			if (rr == 2 && out_row + 1 >= h)
				continue;
			for (int kk = 0; kk < 3; kk++) begin
				if (kk == 0 && out_col == 0)
					continue;
				if (kk == 2 && out_col + 1 >= w)
					continue;
				total += win[rr * 3 + kk];
				cnt++;
			end
		end
		mean = total / (3 * cnt);

		last = (out_row + 1 >= h) && (out_col + 1 >= w);
		if (last) begin
			out_col = 0;
			out_row = 0;
			in_col = 0;
			in_row = 0;
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end

		r.mask_value = (mean >= band_low && mean <= band_high) ? MASK_ON : MASK_OFF;
		r.out_alpha = a_out;
		r.frame_last = last;
		mask_expect.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blur_reset();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_WIDTH:  cfg_width = cfg_wdata[11:0];
					CFG_HEIGHT: cfg_height = cfg_wdata;
					CFG_LOW:    band_low = cfg_wdata[7:0];
					CFG_HIGH:   band_high = cfg_wdata[7:0];
					default:    ;
				endcase
			end
			if (pix_valid && pix_ready)
				blur_predict(pix);
			if (res_valid && res_ready) begin
				if (mask_expect.size() == 0) begin
					$error("unexpected result item: mask_value %0d out_alpha %0d frame_last %0d",
						res.mask_value, res.out_alpha, res.frame_last);
					mismatches++;
				end else begin
					want = mask_expect.pop_front();
					if (res.mask_value !== want.mask_value) begin
						$error("mask_value: expected %0d, got %0d", want.mask_value,
							res.mask_value);
						mismatches++;
					end
					if (res.out_alpha !== want.out_alpha) begin
						$error("out_alpha: expected %0d, got %0d", want.out_alpha,
							res.out_alpha);
						mismatches++;
					end
					if (res.frame_last !== want.frame_last) begin
						$error("frame_last: expected %0d, got %0d", want.frame_last,
							res.frame_last);
						mismatches++;
					end
				end
			end
			pending = mask_expect.size();
		end
	end

endmodule

// ----- dv/tb_box_blur_band_threshold.sv -----
`timescale 1ns / 1ps
// Top of the box_blur_band_threshold testbench: clock, reset, frame stimulus with random idling, result
// back-pressure and the verdict. Depends on bbt_pkg, box_blur_band_threshold and box_blur_band_threshold_checker.
module tb_box_blur_band_threshold;
	import bbt_pkg::*;

	localparam logic [2:0] CFG_SPARE = 3'd7;    // unmapped index, write has no effect
	localparam int TONE_UNIFORM = 0;
	localparam int TONE_EXTREME = 1;
	localparam int TONE_NEAR    = 2;
	localparam int TONE_WHITE   = 3;
	localparam int TONE_BLACK   = 4;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        pix_valid;
	logic        pix_ready;
	pix_t        pix;
	logic        res_valid;
	logic        res_ready;
	res_t        res;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [15:0] cfg_wdata;

	int mismatches;
	int pending;
	int idle_pct;
	int stall_pct;
	int items_sent;
	bit pressure_armed;

	always #6 clk = ~clk;

	box_blur_band_threshold DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	box_blur_band_threshold_checker mask_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always @(negedge clk) begin
		res_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [7:0] near_byte(input int base);
		int v;
		v = base + int'($urandom_range(80)) - 40;
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
	endfunction

	function automatic pix_t rand_pixel(input int tone, input int base);
		pix_t p;
		p.req_type = REQ_PIXEL;
		p.alpha = 8'($urandom);
		case (tone)
			TONE_EXTREME: begin
				p.red   = $urandom_range(1) ? 8'd255 : 8'd0;
				p.green = $urandom_range(1) ? 8'd255 : 8'd0;
				p.blue  = $urandom_range(1) ? 8'd255 : 8'd0;
			end
			TONE_NEAR: begin
				p.red   = near_byte(base);
				p.green = near_byte(base);
				p.blue  = near_byte(base);
			end
			TONE_WHITE: begin
				p.red   = 8'd255;
				p.green = 8'd255;
				p.blue  = 8'd255;
				p.alpha = 8'd255;
			end
			TONE_BLACK: begin
				p.red   = 8'd0;
				p.green = 8'd0;
				p.blue  = 8'd0;
				p.alpha = 8'd0;
			end
			default: begin
				p.red   = 8'($urandom);
				p.green = 8'($urandom);
				p.blue  = 8'($urandom);
			end
		endcase
		return p;
	endfunction

	// flush payload is don't-care, so fill it with noise
	function automatic pix_t flush_item();
		pix_t p;
		p = pix_t'($urandom);
		p.req_type = REQ_FLUSH;
		return p;
	endfunction

	// entered and left at a falling edge; valid stays up for back-to-back items
	task automatic send_item(input pix_t p);
		while ($urandom_range(99) < idle_pct) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix <= p;
		pix_valid <= 1'b1;
		do @(posedge clk); while (!pix_ready);
		@(negedge clk);
	endtask

	task automatic go_quiet();
		pix_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic settle();
		go_quiet();
		wait_drained();
		repeat (8) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_frame(input logic [11:0] wreg, input logic [15:0] hreg,
		input logic [7:0] lo, input logic [7:0] hi, input int tone, input int base,
		input int strays);
		int unsigned w, h, npix;
		w = (wreg == 12'd0) ? 1 : (wreg > MAX_WIDTH) ? MAX_WIDTH : wreg;
		h = (hreg == 16'd0) ? 1 : hreg;
		npix = w * h;
		settle();
		cfg_write(CFG_WIDTH, {4'($urandom_range(15)), wreg});
		cfg_write(CFG_HEIGHT, hreg);
		cfg_write(CFG_LOW, {8'($urandom), lo});
		cfg_write(CFG_HIGH, {8'($urandom), hi});
		repeat (strays) send_item(flush_item());
		for (int i = 0; i < npix; i++) begin
			if (pressure_armed && npix >= 4 && i == npix / 2) begin
				go_quiet();
				wait_drained();
				pressure_armed = 0;
			end
			// a flush inside the frame counts as a black pixel
			if (i > 0 && $urandom_range(99) < 4)
				send_item(flush_item());
			else
				send_item(rand_pixel(tone, base));
		end
		for (int i = 0; i <= w; i++) begin
			if ($urandom_range(99) < 10)
				send_item(rand_pixel(TONE_UNIFORM, 0));
			else
				send_item(flush_item());
		end
		items_sent += npix + w + 1;
	endtask

	task automatic random_frame();
		logic [11:0] wreg;
		logic [15:0] hreg;
		logic [7:0]  lo, hi;
		int          k, t, tone, base, strays;
		wreg = 12'($urandom_range(1, 10));
		hreg = 16'($urandom_range(1, 6));
		if ($urandom_range(19) == 0)
			wreg = 12'd0;
		if ($urandom_range(19) == 0)
			hreg = 16'd0;
		k = $urandom_range(9);
		if (k == 0) begin
			lo = 8'd0;
			hi = 8'd255;
		end else if (k == 1) begin
			lo = 8'($urandom_range(1, 255));
			hi = 8'($urandom_range(0, lo - 1));
		end else if (k == 2) begin
			lo = 8'($urandom);
			hi = lo;
		end else begin
			lo = 8'($urandom);
			t = int'(lo) + int'($urandom_range(60));
			hi = (t > 255) ? 8'd255 : 8'(t);
		end
		base = (lo <= hi) ? (int'(lo) + int'(hi)) / 2 : int'($urandom_range(255));
		k = $urandom_range(9);
		tone = (k < 6) ? TONE_NEAR : (k < 8) ? TONE_UNIFORM : TONE_EXTREME;
		strays = ($urandom_range(9) == 0) ? int'($urandom_range(1, 2)) : 0;
		run_frame(wreg, hreg, lo, hi, tone, base, strays);
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		res_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_WIDTH;
		cfg_wdata = '0;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		pressure_armed = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: unmapped write, stray flush, zero-sized regs, full/empty/point bands
		cfg_write(CFG_SPARE, 16'hFFFF);
		send_item(flush_item());
		run_frame(12'd0, 16'd0, 8'd0, 8'd255, TONE_BLACK, 0, 0);
		run_frame(12'd3, 16'd2, 8'd255, 8'd255, TONE_WHITE, 0, 0);
		run_frame(12'd2, 16'd2, 8'd200, 8'd100, TONE_EXTREME, 0, 0);
		run_frame(12'd1, 16'd3, 8'd0, 8'd0, TONE_BLACK, 0, 1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 64; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 64; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			if (ph == 1)
				pressure_armed = 1;
			target = items_sent + 312;
			while (items_sent < target)
				random_frame();
		end

		go_quiet();
		wait_drained();
		repeat (16) @(negedge clk);
		if (mismatches == 0)
			$display("box_blur_band_threshold test passed");
		else
			$display("box_blur_band_threshold test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("box_blur_band_threshold test failed");
		$finish;
	end

endmodule
